[design/cfa_pkg.sv]
// Shared constants, types and codes for the contiguous fit allocator.
package cfa_pkg;

    // Default number of memory units under management.
    localparam int MEM_UNITS_DEF = 128;

    // Fixed field widths of the stream payloads.
    localparam int SIZE_W      = 8;
    localparam int START_W     = 7;
    localparam int HOLE_W      = 7;
    localparam int USED_W      = 8;
    localparam int MODE_W      = 2;
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 24;

    // Operation codes carried in the input tuser bit.
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // Placement policies.
    typedef enum logic [MODE_W-1:0] {
        FIT_FIRST = 2'd0,
        FIT_BEST  = 2'd1,
        FIT_WORST = 2'd2,
        FIT_NEXT  = 2'd3
    } fit_mode_t;

    // Control from the sequencer to the run search unit.
    typedef struct packed {
        logic clear;
        logic step;
        logic bit_used;
    } run_ctl_t;

endpackage

[design/cfa_map_ram.sv]
// Single-bit occupancy map memory with one write port and one registered read port.
module cfa_map_ram #(
    parameter int DEPTH = cfa_pkg::MEM_UNITS_DEF,
    parameter int AW    = $clog2(cfa_pkg::MEM_UNITS_DEF)
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic          wdata,
    input  logic [AW-1:0] raddr,
    output logic          rdata
);

    logic mem [DEPTH];
    logic rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[design/cfa_run_unit.sv]
// Run tracker that takes one map unit per cycle while stepped and picks a run by policy.
module cfa_run_unit #(
    parameter int MEM_UNITS = cfa_pkg::MEM_UNITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  cfa_pkg::run_ctl_t           ctl,
    input  logic [$clog2(MEM_UNITS)-1:0] pos,
    input  cfa_pkg::fit_mode_t          mode,
    input  logic [cfa_pkg::SIZE_W-1:0]  size,
    input  logic [$clog2(MEM_UNITS)-1:0] cursor,
    output logic                        found,
    output logic [$clog2(MEM_UNITS)-1:0] where_unit
);

    localparam int AW = $clog2(MEM_UNITS);
    localparam int UW = $clog2(MEM_UNITS + 1);
    localparam int CW = (UW > cfa_pkg::SIZE_W) ? UW : cfa_pkg::SIZE_W;
    localparam logic [AW-1:0] LAST_IDX = AW'(MEM_UNITS - 1);

    logic [AW-1:0] run_start_reg, run_start_next;
    logic [UW-1:0] run_len_reg, run_len_next;
    logic          found_reg, found_next;
    logic [AW-1:0] where_reg, where_next;
    logic [UW-1:0] best_reg, best_next;
    logic          up_found_reg, up_found_next;
    logic [AW-1:0] up_where_reg, up_where_next;

    logic          last;
    logic          ev;
    logic [AW-1:0] ev_r;
    logic [UW-1:0] ev_len;
    logic [UW-1:0] ev_end;
    logic [AW-1:0] s1;
    logic          fits;
    logic          up_fits;
    logic          take;
    logic          up_take;

    // A run closes on a used unit or at the top of memory.
    always_comb
    begin
        last    = (pos == LAST_IDX);
        ev      = ctl.step && ((ctl.bit_used && run_len_reg != '0) ||
                               (last && !ctl.bit_used));
        ev_r    = (ctl.bit_used || run_len_reg != '0) ? run_start_reg : pos;
        ev_len  = ctl.bit_used ? run_len_reg : run_len_reg + UW'(1);
        ev_end  = UW'(ev_r) + ev_len;
        s1      = (ev_r > cursor) ? ev_r : cursor;
        fits    = CW'(ev_len) >= CW'(size);
        up_fits = (ev_end > UW'(cursor)) && (CW'(ev_end - UW'(s1)) >= CW'(size));
    end

    // Candidate selection for the closed run.
    always_comb
    begin
        take    = 1'b0;
        up_take = 1'b0;
        case (mode)
            cfa_pkg::FIT_FIRST: take = fits && !found_reg;
            cfa_pkg::FIT_BEST:  take = fits && (!found_reg || ev_len < best_reg);
            cfa_pkg::FIT_WORST: take = fits && (!found_reg || ev_len > best_reg);
            cfa_pkg::FIT_NEXT:
            begin
                // Lower part is the wrapped search below the cursor.
                take    = fits && !found_reg && (ev_r < cursor);
                up_take = up_fits && !up_found_reg;
            end
            default:
            begin
                take    = 1'b0;
                up_take = 1'b0;
            end
        endcase
    end

    // Next-state of the tracker.
    always_comb
    begin
        run_start_next = run_start_reg;
        run_len_next   = run_len_reg;
        found_next     = found_reg;
        where_next     = where_reg;
        best_next      = best_reg;
        up_found_next  = up_found_reg;
        up_where_next  = up_where_reg;
        if (ctl.clear)
        begin
            run_len_next  = '0;
            found_next    = 1'b0;
            up_found_next = 1'b0;
        end
        else if (ctl.step)
        begin
            if (ctl.bit_used)
            begin
                run_len_next = '0;
            end
            else
            begin
                if (run_len_reg == '0)
                begin
                    run_start_next = pos;
                end
                run_len_next = run_len_reg + UW'(1);
            end
            if (ev && take)
            begin
                found_next = 1'b1;
                where_next = ev_r;
                best_next  = ev_len;
            end
            if (ev && up_take)
            begin
                up_found_next = 1'b1;
                up_where_next = s1;
            end
        end
    end

    // Control flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_len_reg  <= '0;
            found_reg    <= 1'b0;
            up_found_reg <= 1'b0;
        end
        else
        begin
            run_len_reg  <= run_len_next;
            found_reg    <= found_next;
            up_found_reg <= up_found_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        run_start_reg <= run_start_next;
        where_reg     <= where_next;
        best_reg      <= best_next;
        up_where_reg  <= up_where_next;
    end

    assign found      = found_reg || (mode == cfa_pkg::FIT_NEXT && up_found_reg);
    assign where_unit = (mode == cfa_pkg::FIT_NEXT && up_found_reg) ? up_where_reg : where_reg;

endmodule

[design/contiguous_fit_allocator.sv]
// Top level of the contiguous fit allocator: sequencer, map sweep and stream ports.
//
// Input stream (s_*): one transaction is one request. s_tuser is the opcode
// (0 allocate, 1 free); s_tdata carries the run size and, for a free, its start.
// Output stream (m_*): one transaction per request with the grant in m_tuser,
// and the placed start, the hole count and the units in use in m_tdata.
// Configuration channel (cfg_*): writes the placement policy; write it only
// while no request is in flight.
//
// After reset the block sweeps the map to clear it, with s_tready low. The
// policy resets to first fit and the next-fit cursor to zero. An allocate
// reads the map once to find a run and then sweeps it once more to mark the
// run and recount holes and used units; a free skips the search and runs only
// the sweep. Both passes are set by the single read port of the map memory,
// one unit a cycle. One request is processed at a time; the result sits in an
// output register, so a new request is taken while it waits, and a stalled
// receiver holds the block only when the next result is ready to be written
// out.
module contiguous_fit_allocator #(
    parameter int MEM_UNITS = cfa_pkg::MEM_UNITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // s_tdata fields from bit 0: region_size[7:0], region_start[14:8], zero pad
    input  logic [cfa_pkg::IN_TDATA_W-1:0]    s_tdata,
    // s_tuser fields from bit 0: opcode
    input  logic                              s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // m_tdata fields from bit 0: placed_start[6:0], hole_count[13:7],
    // used_units[21:14], zero pad
    output logic [cfa_pkg::OUT_TDATA_W-1:0]   m_tdata,
    // m_tuser fields from bit 0: granted
    output logic                              m_tuser,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [cfa_pkg::MODE_W-1:0]        cfg_data
);

    localparam int AW = $clog2(MEM_UNITS);
    localparam int UW = $clog2(MEM_UNITS + 1);
    localparam int CW = (UW > cfa_pkg::SIZE_W) ? UW : cfa_pkg::SIZE_W;
    localparam int LW = (AW > cfa_pkg::START_W) ? AW : cfa_pkg::START_W;
    localparam int EW = LW + 2;
    localparam logic [AW-1:0] LAST_IDX = AW'(MEM_UNITS - 1);

    typedef enum logic [4:0] {
        S_CLEAR  = 5'b00001,
        S_IDLE   = 5'b00010,
        S_SEARCH = 5'b00100,
        S_SWEEP  = 5'b01000,
        S_DONE   = 5'b10000
    } state_t;

    state_t                          state_reg, state_next;
    cfa_pkg::fit_mode_t              mode_reg, mode_next;
    logic [AW-1:0]                   cursor_reg, cursor_next;
    logic [AW-1:0]                   idx_reg, idx_next;
    logic                            iss_reg, iss_next;
    logic                            pv_reg, pv_next;
    logic                            out_valid_reg, out_valid_next;

    logic [cfa_pkg::SIZE_W-1:0]      size_reg, size_next;
    logic [AW-1:0]                   pidx_reg, pidx_next;
    logic [EW-1:0]                   lo_reg, lo_next;
    logic [EW-1:0]                   hi_reg, hi_next;
    logic                            fill_reg, fill_next;
    logic                            grant_reg, grant_next;
    logic [AW-1:0]                   placed_reg, placed_next;
    logic [UW-1:0]                   used_cnt_reg, used_cnt_next;
    logic [UW-1:0]                   hole_cnt_reg, hole_cnt_next;
    logic                            prev_reg, prev_next;
    logic                            granted_out_reg, granted_out_next;
    logic [cfa_pkg::START_W-1:0]     placed_out_reg, placed_out_next;
    logic [cfa_pkg::HOLE_W-1:0]      hole_out_reg, hole_out_next;
    logic [cfa_pkg::USED_W-1:0]      used_out_reg, used_out_next;

    logic                            accept;
    logic                            phase_done;
    logic                            size_ok;
    logic                            rd_data;
    logic                            ram_we;
    logic [AW-1:0]                   ram_waddr;
    logic                            ram_wdata;
    logic                            in_range;
    logic                            new_bit;
    logic [UW-1:0]                   cur_sum;
    logic                            grant_now;
    logic                            unit_found;
    logic [AW-1:0]                   unit_where;
    cfa_pkg::run_ctl_t               run_ctl;
    logic [cfa_pkg::SIZE_W-1:0]      in_size;
    logic [cfa_pkg::START_W-1:0]     in_start;

    // Map memory.
    cfa_map_ram #(
        .DEPTH (MEM_UNITS),
        .AW    (AW)
    ) u_map (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (idx_reg),
        .rdata (rd_data)
    );

    // Shared run search unit.
    cfa_run_unit #(
        .MEM_UNITS (MEM_UNITS)
    ) u_run (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (run_ctl),
        .pos        (pidx_reg),
        .mode       (mode_reg),
        .size       (size_reg),
        .cursor     (cursor_reg),
        .found      (unit_found),
        .where_unit (unit_where)
    );

    // Handshakes and input fields.
    assign s_tready   = (state_reg == S_IDLE);
    assign cfg_ready  = 1'b1;
    assign accept     = s_tvalid && s_tready;
    assign in_size    = s_tdata[7:0];
    assign in_start   = s_tdata[14:8];
    assign phase_done = !iss_reg && !pv_reg;

    // Request checks and sweep datapath.
    always_comb
    begin
        size_ok   = (size_reg != '0) && (CW'(size_reg) <= CW'(MEM_UNITS));
        grant_now = size_ok && unit_found;
        cur_sum   = UW'(unit_where) + UW'(size_reg);
        in_range  = (EW'(pidx_reg) >= lo_reg) && (EW'(pidx_reg) < hi_reg);
        new_bit   = in_range ? fill_reg : rd_data;
    end

    // Sequencer.
    always_comb
    begin
        state_next       = state_reg;
        mode_next        = mode_reg;
        cursor_next      = cursor_reg;
        idx_next         = idx_reg;
        iss_next         = iss_reg;
        pv_next          = 1'b0;
        pidx_next        = idx_reg;
        out_valid_next   = out_valid_reg;
        size_next        = size_reg;
        lo_next          = lo_reg;
        hi_next          = hi_reg;
        fill_next        = fill_reg;
        grant_next       = grant_reg;
        placed_next      = placed_reg;
        used_cnt_next    = used_cnt_reg;
        hole_cnt_next    = hole_cnt_reg;
        prev_next        = prev_reg;
        granted_out_next = granted_out_reg;
        placed_out_next  = placed_out_reg;
        hole_out_next    = hole_out_reg;
        used_out_next    = used_out_reg;
        ram_we           = 1'b0;
        ram_waddr        = pidx_reg;
        ram_wdata        = new_bit;
        run_ctl.clear    = 1'b0;
        run_ctl.step     = 1'b0;
        run_ctl.bit_used = rd_data;

        // Configuration write.
        if (cfg_valid && cfg_ready)
        begin
            mode_next = cfa_pkg::fit_mode_t'(cfg_data);
        end

        // Output register drains on a completed transaction.
        if (m_tready)
        begin
            out_valid_next = 1'b0;
        end

        // Address issue shared by both map passes.
        if ((state_reg == S_SEARCH || state_reg == S_SWEEP) && iss_reg)
        begin
            pv_next  = 1'b1;
            idx_next = idx_reg + AW'(1);
            if (idx_reg == LAST_IDX)
            begin
                iss_next = 1'b0;
            end
        end

        case (state_reg)
            S_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = idx_reg;
                ram_wdata = 1'b0;
                idx_next  = idx_reg + AW'(1);
                if (idx_reg == LAST_IDX)
                begin
                    idx_next   = '0;
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    size_next     = in_size;
                    idx_next      = '0;
                    iss_next      = 1'b1;
                    used_cnt_next = '0;
                    hole_cnt_next = '0;
                    prev_next     = 1'b0;
                    if (s_tuser == cfa_pkg::OP_ALLOC)
                    begin
                        run_ctl.clear = 1'b1;
                        state_next    = S_SEARCH;
                    end
                    else
                    begin
                        lo_next     = EW'(in_start);
                        hi_next     = EW'(in_start) + EW'(in_size);
                        fill_next   = 1'b0;
                        grant_next  = 1'b1;
                        placed_next = '0;
                        state_next  = S_SWEEP;
                    end
                end
            end
            S_SEARCH:
            begin
                run_ctl.step = pv_reg;
                if (phase_done)
                begin
                    // A refused request leaves an empty marking window.
                    grant_next  = grant_now;
                    placed_next = grant_now ? unit_where : '0;
                    lo_next     = grant_now ? EW'(unit_where) : '0;
                    hi_next     = grant_now ? EW'(unit_where) + EW'(size_reg) : '0;
                    fill_next   = 1'b1;
                    if (grant_now)
                    begin
                        cursor_next = (cur_sum == UW'(MEM_UNITS)) ? '0 : AW'(cur_sum);
                    end
                    idx_next   = '0;
                    iss_next   = 1'b1;
                    state_next = S_SWEEP;
                end
            end
            S_SWEEP:
            begin
                // Read-modify-write of each unit with a running recount.
                if (pv_reg)
                begin
                    ram_we        = 1'b1;
                    used_cnt_next = used_cnt_reg + UW'(new_bit);
                    hole_cnt_next = hole_cnt_reg + UW'(prev_reg && !new_bit);
                    prev_next     = new_bit;
                end
                if (phase_done)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next   = 1'b1;
                    granted_out_next = grant_reg;
                    placed_out_next  = cfa_pkg::START_W'(placed_reg);
                    hole_out_next    = cfa_pkg::HOLE_W'(hole_cnt_reg);
                    used_out_next    = cfa_pkg::USED_W'(used_cnt_reg);
                    state_next       = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            mode_reg      <= cfa_pkg::FIT_FIRST;
            cursor_reg    <= '0;
            idx_reg       <= '0;
            iss_reg       <= 1'b0;
            pv_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            mode_reg      <= mode_next;
            cursor_reg    <= cursor_next;
            idx_reg       <= idx_next;
            iss_reg       <= iss_next;
            pv_reg        <= pv_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        size_reg        <= size_next;
        pidx_reg        <= pidx_next;
        lo_reg          <= lo_next;
        hi_reg          <= hi_next;
        fill_reg        <= fill_next;
        grant_reg       <= grant_next;
        placed_reg      <= placed_next;
        used_cnt_reg    <= used_cnt_next;
        hole_cnt_reg    <= hole_cnt_next;
        prev_reg        <= prev_next;
        granted_out_reg <= granted_out_next;
        placed_out_reg  <= placed_out_next;
        hole_out_reg    <= hole_out_next;
        used_out_reg    <= used_out_next;
    end

    // Output stream.
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = granted_out_reg;
    assign m_tdata  = {2'b00, used_out_reg, hole_out_reg, placed_out_reg};

    // A refused allocation reports start zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser) |-> (m_tdata[6:0] == 7'd0))
        else $error("refused request reports a nonzero start");

    // Read data is only consumed during a map pass.
    assert property (@(posedge clk) disable iff (!rst_n)
        pv_reg |-> (state_reg == S_SEARCH || state_reg == S_SWEEP))
        else $error("map read pipeline active outside a pass");

    // Recount results stay within the map.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE) |-> (used_cnt_reg <= UW'(MEM_UNITS) &&
                                   hole_cnt_reg <= used_cnt_reg))
        else $error("hole or used count out of range");

    // A granted allocation lies wholly inside the map.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SEARCH && phase_done && grant_now) |->
            (cur_sum <= UW'(MEM_UNITS)))
        else $error("granted run crosses the top of the map");

    // The next-fit cursor always names a unit.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SWEEP) |=> (32'(cursor_reg) < MEM_UNITS))
        else $error("next-fit cursor out of range");

endmodule
